// ===== hw/rtl/wat_pkg.sv =====
// Shared widths, register indexes and divider status type for the window reporter.
`timescale 1ns / 1ps

package wat_pkg;

	// Field widths.
	localparam int LEVEL_W = 16;
	localparam int POS_W   = 24;

	// Stream word layout.
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 64;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Threshold after reset: 75 dB in Q8.8.
	localparam logic [LEVEL_W-1:0] THRESH_RESET = 16'd19200;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOBILE_MODE = 2'd0,
		CFG_SENSOR_X    = 2'd1,
		CFG_SENSOR_Y    = 2'd2,
		CFG_THRESHOLD   = 2'd3
	} cfg_index_t;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hw/rtl/wat_div.sv =====
// Divider by a fixed divisor: reciprocal multiplication with a registered dividend and a registered product.
`timescale 1ns / 1ps

module wat_div #(
	parameter int WIDTH   = 27,
	parameter int DIVISOR = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIDTH-1:0]     dividend,
	output logic [WIDTH-1:0]     quotient,
	output wat_pkg::div_stat_t   stat
);

	// floor(x / DIVISOR) equals (x * RECIP) >> SHIFT for every WIDTH-bit x.
	localparam int SHIFT = WIDTH + $clog2(DIVISOR);
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam int RECIP_W = $clog2(RECIP + 64'd1);
	localparam int PROD_W  = WIDTH + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	logic [WIDTH-1:0]  dvd_q;
	logic [PROD_W-1:0] prod_q;
	logic              busy_q;
	logic              done_q;

	// Control: the dividend is taken on start, the product in the following cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// Datapath: registered dividend, then registered product.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end
		if (busy_q) begin
			prod_q <= PROD_W'(dvd_q) * PROD_W'(RECIP_C);
		end
	end

	assign quotient  = WIDTH'(prod_q >> SHIFT);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// A new division is never started on top of a running one.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");

	// Done follows in the cycle after the multiply step.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");

	// The multiply step lasts a single cycle.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q) else $error("divider busy for more than one cycle");

endmodule

// ===== hw/rtl/wat_ring.sv =====
// Ring store of levels and positions with one write and one registered read port.
`timescale 1ns / 1ps

module wat_ring #(
	parameter int DEPTH = 6
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [wat_pkg::LEVEL_W-1:0]   wr_level,
	input  logic [wat_pkg::POS_W-1:0]     wr_x,
	input  logic [wat_pkg::POS_W-1:0]     wr_y,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [wat_pkg::LEVEL_W-1:0]   rd_level,
	output logic [wat_pkg::POS_W-1:0]     rd_x,
	output logic [wat_pkg::POS_W-1:0]     rd_y
);

	logic [wat_pkg::LEVEL_W-1:0] level_mem [DEPTH];
	logic [wat_pkg::POS_W-1:0]   x_mem     [DEPTH];
	logic [wat_pkg::POS_W-1:0]   y_mem     [DEPTH];
	logic [wat_pkg::LEVEL_W-1:0] level_q;
	logic [wat_pkg::POS_W-1:0]   x_q;
	logic [wat_pkg::POS_W-1:0]   y_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			level_mem[wr_addr] <= wr_level;
			x_mem[wr_addr]     <= wr_x;
			y_mem[wr_addr]     <= wr_y;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			level_q <= level_mem[rd_addr];
			x_q     <= x_mem[rd_addr];
			y_q     <= y_mem[rd_addr];
		end
	end

	assign rd_level = level_q;
	assign rd_x     = x_q;
	assign rd_y     = y_q;

endmodule

// ===== hw/rtl/window_average_threshold_reporter.sv =====
// Top level: sample ring, sequencer, shared divider and output register (D = WINDOW_DEPTH).
// A reporting sample runs ST_SUM over the window, ST_DRAIN and ST_DIVL for the level average;
// a summary then runs ST_DIVX and ST_DIVY (mobile mode only) and ST_AVG, and a dump alternates
// ST_DUMP_RD and ST_DUMP_WR once per word. s_tready stays low until the sequencer is idle again,
// output stalls included; a sample that does not report leaves s_tready high.
// Reset (arst_n low, asynchronous) clears the write slot, full flag, sequencer and output.
`timescale 1ns / 1ps

module window_average_threshold_reporter #(
	parameter int WINDOW_DEPTH = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input samples.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wat_pkg::IN_DATA_W-1:0]     s_tdata,  // noise_level, pos_x, pos_y
	input  logic [0:0]                        s_tuser,  // link_up
	// Reports.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wat_pkg::OUT_DATA_W-1:0]    m_tdata,  // report_x, report_y, report_level
	output logic [0:0]                        m_tuser,  // is_average
	output logic                              m_tlast,
	// Register writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wat_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wat_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int LSUM_W = wat_pkg::LEVEL_W + IDX_W;
	localparam int PSUM_W = wat_pkg::POS_W + IDX_W;
	localparam int LV_W   = wat_pkg::LEVEL_W;
	localparam int PS_W   = wat_pkg::POS_W;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_SUM     = 9'b000000010,
		ST_DRAIN   = 9'b000000100,
		ST_DIVL    = 9'b000001000,
		ST_DIVX    = 9'b000010000,
		ST_DIVY    = 9'b000100000,
		ST_AVG     = 9'b001000000,
		ST_DUMP_RD = 9'b010000000,
		ST_DUMP_WR = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic            mobile_q;
	logic [PS_W-1:0] sensor_x_q;
	logic [PS_W-1:0] sensor_y_q;
	logic [LV_W-1:0] thresh_q;

	// Window bookkeeping.
	logic [IDX_W-1:0] slot_q;
	logic             full_q;
	logic [IDX_W-1:0] idx_q;
	logic             rd_vld_s1;

	// Sums and averages.
	logic [LSUM_W-1:0]        lsum_q;
	logic signed [PSUM_W-1:0] xsum_q;
	logic signed [PSUM_W-1:0] ysum_q;
	logic [LV_W-1:0]          lavg_q;
	logic [PS_W-1:0]          xavg_q;
	logic [PS_W-1:0]          yavg_q;

	// Divider hookup.
	logic                     div_run_q;
	logic                     div_start;
	logic [PSUM_W-1:0]        div_dvd;
	logic [PSUM_W-1:0]        div_quo;
	wat_pkg::div_stat_t       div_stat;
	logic [PSUM_W-1:0]        xs_u;
	logic [PSUM_W-1:0]        ys_u;
	logic [PSUM_W-1:0]        xmag;
	logic [PSUM_W-1:0]        ymag;
	logic                     xneg;
	logic                     yneg;
	logic [PSUM_W-1:0]        quo_neg;

	// Ring ports.
	logic             in_acc;
	logic             link_up;
	logic             rd_en;
	logic [LV_W-1:0]  rd_level;
	logic [PS_W-1:0]  rd_x;
	logic [PS_W-1:0]  rd_y;
	logic             full_next;

	// Output register.
	logic                           out_vld_q;
	logic [wat_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_avg_q;
	logic                           out_last_q;
	logic                           out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign link_up   = s_tuser[0];
	assign full_next = full_q || (slot_q == IDX_W'(WINDOW_DEPTH - 1));
	assign out_free  = !out_vld_q || m_tready;
	assign rd_en     = (state_q == ST_SUM) || (state_q == ST_DUMP_RD);

	// Register write decoder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mobile_q   <= 1'b0;
			sensor_x_q <= '0;
			sensor_y_q <= '0;
			thresh_q   <= wat_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wat_pkg::CFG_MOBILE_MODE: mobile_q   <= cfg_data[0];
				wat_pkg::CFG_SENSOR_X:    sensor_x_q <= cfg_data[PS_W-1:0];
				wat_pkg::CFG_SENSOR_Y:    sensor_y_q <= cfg_data[PS_W-1:0];
				wat_pkg::CFG_THRESHOLD:   thresh_q   <= cfg_data[LV_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample store.
	wat_ring #(
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk      (clk),
		.wr_en    (in_acc),
		.wr_addr  (slot_q),
		.wr_level (s_tdata[15:0]),
		.wr_x     (s_tdata[39:16]),
		.wr_y     (s_tdata[63:40]),
		.rd_en    (rd_en),
		.rd_addr  (idx_q),
		.rd_level (rd_level),
		.rd_x     (rd_x),
		.rd_y     (rd_y)
	);

	// Dividend selection; negative sums divide their magnitude plus D-1 for a floor.
	always_comb begin
		xs_u = xsum_q;
		ys_u = ysum_q;
		xneg = xs_u[PSUM_W-1];
		yneg = ys_u[PSUM_W-1];
		xmag = xneg ? ((~xs_u) + PSUM_W'(WINDOW_DEPTH)) : xs_u;
		ymag = yneg ? ((~ys_u) + PSUM_W'(WINDOW_DEPTH)) : ys_u;
		case (state_q)
			ST_DIVX: div_dvd = xmag;
			ST_DIVY: div_dvd = ymag;
			default: div_dvd = PSUM_W'(lsum_q);
		endcase
		div_start = ((state_q == ST_DIVL) || (state_q == ST_DIVX) || (state_q == ST_DIVY))
			&& !div_run_q;
		quo_neg = PSUM_W'(0) - div_quo;
	end

	wat_div #(
		.WIDTH   (PSUM_W),
		.DIVISOR (WINDOW_DEPTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Window sums, one entry per cycle from the registered read port.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lsum_q <= '0;
			xsum_q <= '0;
			ysum_q <= '0;
		end else if (rd_vld_s1) begin
			lsum_q <= lsum_q + LSUM_W'(rd_level);
			xsum_q <= xsum_q + PSUM_W'($signed(rd_x));
			ysum_q <= ysum_q + PSUM_W'($signed(rd_y));
		end
	end

	// Captured averages.
	always_ff @(posedge clk) begin
		if (div_stat.done) begin
			case (state_q)
				ST_DIVX: xavg_q <= xneg ? quo_neg[PS_W-1:0] : div_quo[PS_W-1:0];
				ST_DIVY: yavg_q <= yneg ? quo_neg[PS_W-1:0] : div_quo[PS_W-1:0];
				default: lavg_q <= div_quo[LV_W-1:0];
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_q     <= '0;
			full_q     <= 1'b0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			div_run_q  <= 1'b0;
			out_vld_q  <= 1'b0;
			out_avg_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SUM);
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (div_start) begin
				div_run_q <= 1'b1;
			end else if (div_stat.done) begin
				div_run_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						full_q <= full_next;
						if (link_up) begin
							slot_q <= (slot_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0
								: slot_q + IDX_W'(1);
							idx_q  <= '0;
							if (full_next) begin
								state_q <= ST_SUM;
							end
						end
					end
				end
				ST_SUM: begin
					if (idx_q == IDX_W'(WINDOW_DEPTH - 1)) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DIVL;
				end
				ST_DIVL: begin
					if (div_stat.done) begin
						if (div_quo[LV_W-1:0] <= thresh_q) begin
							state_q <= mobile_q ? ST_DIVX : ST_AVG;
						end else begin
							state_q <= ST_DUMP_RD;
						end
					end
				end
				ST_DIVX: begin
					if (div_stat.done) begin
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_stat.done) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_avg_q  <= 1'b1;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_WR;
				end
				ST_DUMP_WR: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_avg_q  <= 1'b0;
						out_last_q <= (idx_q == IDX_W'(WINDOW_DEPTH - 1));
						if (idx_q == IDX_W'(WINDOW_DEPTH - 1)) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_DUMP_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_AVG) && out_free) begin
			out_data_q <= {lavg_q,
				mobile_q ? yavg_q : sensor_y_q,
				mobile_q ? xavg_q : sensor_x_q};
		end else if ((state_q == ST_DUMP_WR) && out_free) begin
			out_data_q <= {rd_level,
				mobile_q ? rd_y : sensor_y_q,
				mobile_q ? rd_x : sensor_x_q};
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_avg_q;
	assign m_tlast    = out_last_q;

	// A sample with the link down leaves the write slot where it was.
	a_link_down_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !link_up) |=> (slot_q == $past(slot_q)))
		else $error("write slot moved while link down");

	// Once the window has filled it stays full.
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q) else $error("window full flag dropped");

	// The write slot stays inside the window.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_q < IDX_W'(WINDOW_DEPTH - 1)) || (slot_q == IDX_W'(WINDOW_DEPTH - 1)))
		else $error("write slot out of range");

	// A summary word is always the only word of its sample.
	a_avg_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_avg_q) |-> out_last_q)
		else $error("summary word not marked last");

	// No word is produced before the window has filled.
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> full_q) else $error("word sent before window filled");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the window average threshold reporter, with predictor and scoreboard.
`timescale 1ns / 1ps

module tb_top;

	localparam int POS_W      = wat_pkg::POS_W;
	localparam int LEVEL_W    = wat_pkg::LEVEL_W;
	localparam int IN_DATA_W  = wat_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = wat_pkg::OUT_DATA_W;
	localparam int CFG_DATA_W = wat_pkg::CFG_DATA_W;
	localparam int WIN = 6;
	localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;
	localparam int PHASE_ITEMS = 75;
	localparam int SETTLE_CYCLES = 150;

	// One sensor reading as it enters the block.
	typedef struct {
		logic [LEVEL_W-1:0]      level;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    up;
	} reading_t;

	// One report word as it leaves the block.
	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [LEVEL_W-1:0]      level;
		logic                    is_avg;
		logic                    last;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	wat_pkg::cfg_index_t   cfg_index = wat_pkg::CFG_MOBILE_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	window_average_threshold_reporter #(
		.WINDOW_DEPTH(WIN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Readings waiting to be sent and reports waiting to arrive.
	reading_t reading_queue[$];
	report_t  pending_reports[$];
	int       mismatches = 0;
	bit       calm = 1'b0;

	// Mirror of the registers.
	logic                    cur_mobile = 1'b0;
	logic signed [POS_W-1:0] cur_sensor_x = '0;
	logic signed [POS_W-1:0] cur_sensor_y = '0;
	logic [LEVEL_W-1:0]      cur_threshold = wat_pkg::THRESH_RESET;

	// Mirror of the sample ring.
	logic [LEVEL_W-1:0]      level_ring [WIN];
	logic signed [POS_W-1:0] x_ring [WIN];
	logic signed [POS_W-1:0] y_ring [WIN];
	int                      ring_slot = 0;
	bit                      ring_full = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Average that rounds toward negative infinity.
	function automatic logic signed [POS_W-1:0] floor_avg(input longint total);
		longint q;
		q = total / WIN;
		if ((total % WIN) != 0 && total < 0)
			q = q - 1;
		return q[POS_W-1:0];
	endfunction

	// Store one reading in the ring and queue the reports it causes.
	task automatic forecast_reports(input reading_t rd);
		longint lsum;
		longint xsum;
		longint ysum;
		logic [LEVEL_W-1:0] lavg;
		report_t r;
		lsum = 0;
		xsum = 0;
		ysum = 0;
		if (ring_slot == WIN - 1)
			ring_full = 1'b1;
		level_ring[ring_slot] = rd.level;
		x_ring[ring_slot] = rd.x;
		y_ring[ring_slot] = rd.y;
		// With the link down the slot stays where it is.
		if (!rd.up)
			return;
		for (int i = 0; i < WIN; i++) begin
			lsum = lsum + level_ring[i];
			xsum = xsum + x_ring[i];
			ysum = ysum + y_ring[i];
		end
		lavg = LEVEL_W'(lsum / WIN);
		if (ring_full) begin
			if (lavg <= cur_threshold) begin
				r.x = cur_mobile ? floor_avg(xsum) : cur_sensor_x;
				r.y = cur_mobile ? floor_avg(ysum) : cur_sensor_y;
				r.level = lavg;
				r.is_avg = 1'b1;
				r.last = 1'b1;
				pending_reports.push_back(r);
			end else begin
				// Level too high: every stored entry goes out in slot order.
				for (int i = 0; i < WIN; i++) begin
					r.x = cur_mobile ? x_ring[i] : cur_sensor_x;
					r.y = cur_mobile ? y_ring[i] : cur_sensor_y;
					r.level = level_ring[i];
					r.is_avg = 1'b0;
					r.last = (i == WIN - 1);
					pending_reports.push_back(r);
				end
			end
		end
		ring_slot = (ring_slot + 1) % WIN;
	endtask

	// Input driver: one word at a time, with a random gap before each.
	reading_t in_flight;
	int       gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				forecast_reports(in_flight);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (reading_queue.size() > 0) begin
					in_flight = reading_queue.pop_front();
					s_tdata <= {in_flight.y, in_flight.x, in_flight.level};
					s_tuser <= in_flight.up;
					s_tvalid <= 1'b1;
					gap_left = calm ? 0 : $urandom_range(0, 5);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each word and stalls at random, once for a long stretch.
	report_t want;
	int      hold_left = 0;
	int      reports_seen = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_reports.size() == 0) begin
					$error("unexpected report word: data %h, is_average %0d, last %0d",
						m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (m_tdata[23:0] !== want.x) begin
						$error("report_x: expected %0d, actual %0d",
							want.x, $signed(m_tdata[23:0]));
						mismatches++;
					end
					if (m_tdata[47:24] !== want.y) begin
						$error("report_y: expected %0d, actual %0d",
							want.y, $signed(m_tdata[47:24]));
						mismatches++;
					end
					if (m_tdata[63:48] !== want.level) begin
						$error("report_level: expected %0d, actual %0d",
							want.level, m_tdata[63:48]);
						mismatches++;
					end
					if (m_tuser[0] !== want.is_avg) begin
						$error("is_average: expected %0d, actual %0d", want.is_avg, m_tuser);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, m_tlast);
						mismatches++;
					end
				end
				reports_seen++;
				hold_left = calm ? 0 : $urandom_range(0, 5);
				// A long hold-off lets the block back up into its input.
				if (reports_seen == 100)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Register write over the configuration channel; the mirror follows at the handshake.
	task automatic write_reg(input wat_pkg::cfg_index_t idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			wat_pkg::CFG_MOBILE_MODE: cur_mobile = val[0];
			wat_pkg::CFG_SENSOR_X:    cur_sensor_x = val;
			wat_pkg::CFG_SENSOR_Y:    cur_sensor_y = val;
			wat_pkg::CFG_THRESHOLD:   cur_threshold = val[LEVEL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic add_reading(input logic [LEVEL_W-1:0] lvl, input logic signed [POS_W-1:0] x,
		input logic signed [POS_W-1:0] y, input logic up);
		reading_t rd;
		rd.level = lvl;
		rd.x = x;
		rd.y = y;
		rd.up = up;
		reading_queue.push_back(rd);
	endtask

	// Wait until every reading is sent and every report is in, then let the block settle.
	task automatic drain();
		do @(negedge clk);
		while (reading_queue.size() != 0 || s_tvalid || pending_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random position, now and then one of the corner values.
	function automatic logic signed [POS_W-1:0] rand_pos();
		logic [31:0] r;
		r = $urandom();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: return POS_MAX;
				1: return POS_MIN;
				2: return '0;
				default: return -24'sd1;
			endcase
		end
		return r[POS_W-1:0];
	endfunction

	// Random level, mostly near the threshold so both report kinds show up.
	function automatic logic [LEVEL_W-1:0] rand_level();
		int v;
		if ($urandom_range(0, 2) == 0)
			return LEVEL_W'($urandom_range(0, 65535));
		v = int'(cur_threshold) + int'($urandom_range(0, 4000)) - 2000;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[LEVEL_W-1:0];
	endfunction

	initial begin
		logic [31:0] r;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Filling the window under the reset settings, link drops, exact threshold.
		add_reading(16'd0, POS_MAX, POS_MIN, 1'b1);
		add_reading(LEVEL_MAX, 24'sd0, 24'sd0, 1'b0);
		add_reading(LEVEL_MAX, POS_MIN, POS_MAX, 1'b1);
		add_reading(16'd0, -24'sd1, 24'sd1, 1'b1);
		add_reading(16'd0, 24'sd0, 24'sd0, 1'b1);
		add_reading(16'd1, 24'sd0, 24'sd0, 1'b1);
		add_reading(16'd0, 24'sd5, 24'sd5, 1'b0);
		add_reading(16'd0, 24'sd7, -24'sd7, 1'b1);
		add_reading(LEVEL_MAX, 24'sd0, 24'sd0, 1'b1);
		add_reading(16'd0, 24'sd0, 24'sd0, 1'b0);
		add_reading(16'd49664, 24'sd0, 24'sd0, 1'b1);
		add_reading(16'd6, 24'sd0, 24'sd0, 1'b1);
		drain();

		// Mobile mode with the highest threshold: summaries with negative averages.
		write_reg(wat_pkg::CFG_MOBILE_MODE, 24'd1);
		write_reg(wat_pkg::CFG_SENSOR_X, POS_MIN);
		write_reg(wat_pkg::CFG_SENSOR_Y, POS_MAX);
		write_reg(wat_pkg::CFG_THRESHOLD, 24'(LEVEL_MAX));
		add_reading(LEVEL_MAX, POS_MIN, POS_MAX, 1'b1);
		add_reading(LEVEL_MAX, POS_MIN, POS_MAX, 1'b1);
		add_reading(16'd0, -24'sd1, 24'sd1, 1'b1);
		add_reading(16'd0, -24'sd1, 24'sd1, 1'b1);
		add_reading(16'd0, 24'sd0, 24'sd0, 1'b1);
		add_reading(16'd0, 24'sd0, 24'sd0, 1'b1);
		drain();

		// Zero threshold: a dump, then two summaries whose level average is zero.
		write_reg(wat_pkg::CFG_THRESHOLD, 24'd0);
		add_reading(16'd0, 24'sd3, -24'sd3, 1'b1);
		add_reading(16'd0, 24'sd3, -24'sd3, 1'b1);
		add_reading(16'd1, POS_MAX, POS_MIN, 1'b1);
		drain();

		// Static mode at the coordinate extremes.
		write_reg(wat_pkg::CFG_MOBILE_MODE, 24'd0);
		write_reg(wat_pkg::CFG_THRESHOLD, 24'(LEVEL_MAX));
		add_reading(LEVEL_MAX, POS_MAX, POS_MAX, 1'b1);
		add_reading(16'd0, POS_MIN, POS_MIN, 1'b1);
		add_reading(16'd2, 24'sd9, 24'sd9, 1'b1);
		drain();

		// Random phases, each under its own settings.
		for (int p = 0; p < 6; p++) begin
			calm = (p == 4);
			write_reg(wat_pkg::CFG_MOBILE_MODE, 24'(p % 2));
			r = $urandom();
			write_reg(wat_pkg::CFG_SENSOR_X,
				(p == 0) ? POS_MAX : (p == 1) ? POS_MIN : r[23:0]);
			r = $urandom();
			write_reg(wat_pkg::CFG_SENSOR_Y,
				(p == 0) ? POS_MIN : (p == 1) ? POS_MAX : r[23:0]);
			if (p == 2)
				write_reg(wat_pkg::CFG_THRESHOLD, 24'd0);
			else if (p == 3)
				write_reg(wat_pkg::CFG_THRESHOLD, 24'(LEVEL_MAX));
			else
				write_reg(wat_pkg::CFG_THRESHOLD, 24'($urandom_range(0, 65535)));
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_reading(rand_level(), rand_pos(), rand_pos(), $urandom_range(0, 9) != 0);
			drain();
		end

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog for a stuck handshake.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
